// ----- hdl/i2cbm_pkg.sv -----
// Shared types, codes and helpers for the I2C bit-level master.
package i2cbm_pkg;

   localparam logic [2:0] FUNC_START = 3'd1;
   localparam logic [2:0] FUNC_STOP  = 3'd2;
   localparam logic [2:0] FUNC_WRITE = 3'd3;
   localparam logic [2:0] FUNC_READ  = 3'd4;

   localparam logic [2:0] CSR_ADDR_UNIT    = 3'd0;
   localparam logic [2:0] CSR_ADDR_TIMEOUT = 3'd4;

   localparam logic [15:0] UNIT_TICKS_RESET  = 16'd100;
   localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd250;

   // delay lengths as left shifts of the unit
   localparam logic [1:0] DLY_1U = 2'd0;
   localparam logic [1:0] DLY_2U = 2'd1;
   localparam logic [1:0] DLY_4U = 2'd2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_ST_A,
      PH_ST_B,
      PH_SP_A,
      PH_SP_B,
      PH_WR_LO,
      PH_WR_HI,
      PH_WR_TAIL,
      PH_AK_REL,
      PH_AK_HI,
      PH_AK_POLL,
      PH_RD_LO,
      PH_RD_HI,
      PH_AC_LO,
      PH_AC_HI
   } phase_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_START,
      CMD_STOP,
      CMD_WRITE,
      CMD_READ
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] tx_byte;
      logic       send_ack;
      logic       sda_in;
   } item_type;

   typedef struct packed {
      logic       ack_failed;
      logic [7:0] rx_byte;
      logic       done_res;
      logic       busy_res;
      logic       sda_drive_en;
      logic       sda_out;
      logic       scl_out;
   } result_type;

   function automatic logic [17:0] calc_delay(input logic [15:0] unit, input logic [1:0] sh);
      logic [17:0] d;
      d = {2'b00, unit} << sh;
      return (d == 18'd0) ? 18'd1 : d;
   endfunction

endpackage

// ----- hdl/i2cbm_front.sv -----
// Request decode and command queue in front of the bit engine.
module i2cbm_front
   import i2cbm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,
   output logic        q_valid,
   output item_type    q_item,
   input  logic        q_pop
);

   item_type              mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;
   item_type              item;
   logic                  push;
   logic                  pop;

   always_comb begin
      unique case (req_tdata[2:0])
         FUNC_START: item.cmd = CMD_START;
         FUNC_STOP:  item.cmd = CMD_STOP;
         FUNC_WRITE: item.cmd = CMD_WRITE;
         FUNC_READ:  item.cmd = CMD_READ;
         default:    item.cmd = CMD_NONE;
      endcase
      item.tx_byte  = req_tdata[10:3];
      item.send_ack = req_tdata[11];
      item.sda_in   = req_tdata[12];
   end

   assign req_tready = (count_ff != QUEUE_CW'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != '0);
   assign pop        = q_pop && q_valid;
   assign q_item     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CW'(push) - QUEUE_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

// ----- hdl/i2cbm_engine.sv -----
// Bit engine: one tick of the I2C sequencer per request, with result register.
module i2cbm_engine
   import i2cbm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  item_type    q_item,
   output logic        q_pop,
   input  logic [15:0] unit_ticks,
   input  logic [15:0] ack_timeout_ticks,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output result_type  rsp_result
);

   phase_type   phase_ff, phase_in;
   logic [3:0]  bit_ff, bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic [17:0] delay_ff, delay_in;
   logic [15:0] wait_ff, wait_in;
   logic        ack_ff, ack_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;
   logic        en_ff, en_in;
   logic        fail_ff, fail_in;
   logic [7:0]  rx_ff, rx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff, rsp_in;
   logic        step;
   logic        done;
   logic [17:0] dec;

   assign step       = q_valid && (!rsp_valid_ff || rsp_ready);
   assign q_pop      = step;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;
   assign dec        = (delay_ff != 18'd0) ? delay_ff - 18'd1 : 18'd0;

   always_comb begin
      phase_in = phase_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      delay_in = delay_ff;
      wait_in  = wait_ff;
      ack_in   = ack_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      en_in    = en_ff;
      fail_in  = fail_ff;
      rx_in    = rx_ff;
      done     = 1'b0;
      if (step) begin
         unique case (phase_ff)
            PH_IDLE: begin
               unique case (q_item.cmd)
                  CMD_START: begin
                     scl_in = 1'b1; sda_in = 1'b1; en_in = 1'b1;
                     delay_in = calc_delay(unit_ticks, DLY_4U);
                     phase_in = PH_ST_A;
                  end
                  CMD_STOP: begin
                     scl_in = 1'b0; sda_in = 1'b0; en_in = 1'b1;
                     delay_in = calc_delay(unit_ticks, DLY_4U);
                     phase_in = PH_SP_A;
                  end
                  CMD_WRITE: begin
                     fail_in  = 1'b0;
                     bit_in   = 4'd0;
                     scl_in = 1'b0; sda_in = q_item.tx_byte[7]; en_in = 1'b1;
                     shift_in = {q_item.tx_byte[6:0], 1'b0};
                     delay_in = calc_delay(unit_ticks, DLY_2U);
                     phase_in = PH_WR_LO;
                  end
                  CMD_READ: begin
                     ack_in   = q_item.send_ack;
                     bit_in   = 4'd0;
                     shift_in = 8'd0;
                     scl_in = 1'b0; sda_in = 1'b1; en_in = 1'b0;
                     delay_in = calc_delay(unit_ticks, DLY_2U);
                     phase_in = PH_RD_LO;
                  end
                  default: ;
               endcase
            end
            PH_AK_POLL: begin
               if (!q_item.sda_in) begin
                  scl_in = 1'b0; sda_in = 1'b1; en_in = 1'b0;
                  phase_in = PH_IDLE;
                  done     = 1'b1;
               end else if (wait_ff >= ack_timeout_ticks) begin
                  fail_in = 1'b1;
                  scl_in = 1'b0; sda_in = 1'b0; en_in = 1'b1;
                  delay_in = calc_delay(unit_ticks, DLY_4U);
                  phase_in = PH_SP_A;
               end else begin
                  wait_in = wait_ff + 16'd1;
               end
            end
            default: begin
               delay_in = dec;
               if (dec == 18'd0) begin
                  unique case (phase_ff)
                     PH_ST_A: begin
                        sda_in = 1'b0; en_in = 1'b1;
                        delay_in = calc_delay(unit_ticks, DLY_4U);
                        phase_in = PH_ST_B;
                     end
                     PH_ST_B: begin
                        scl_in = 1'b0; sda_in = 1'b0; en_in = 1'b1;
                        phase_in = PH_IDLE;
                        done     = 1'b1;
                     end
                     PH_SP_A: begin
                        scl_in = 1'b1; sda_in = 1'b1; en_in = 1'b1;
                        delay_in = calc_delay(unit_ticks, DLY_4U);
                        phase_in = PH_SP_B;
                     end
                     PH_SP_B: begin
                        phase_in = PH_IDLE;
                        done     = 1'b1;
                     end
                     PH_WR_LO: begin
                        scl_in = 1'b1; en_in = 1'b1;
                        delay_in = calc_delay(unit_ticks, DLY_2U);
                        phase_in = PH_WR_HI;
                     end
                     PH_WR_HI: begin
                        scl_in = 1'b0; en_in = 1'b1;
                        delay_in = calc_delay(unit_ticks, DLY_2U);
                        phase_in = PH_WR_TAIL;
                     end
                     PH_WR_TAIL: begin
                        bit_in = bit_ff + 4'd1;
                        if (bit_in < 4'd8) begin
                           scl_in = 1'b0; sda_in = shift_ff[7]; en_in = 1'b1;
                           shift_in = {shift_ff[6:0], 1'b0};
                           delay_in = calc_delay(unit_ticks, DLY_2U);
                           phase_in = PH_WR_LO;
                        end else begin
                           scl_in = 1'b0; sda_in = 1'b1; en_in = 1'b0;
                           delay_in = calc_delay(unit_ticks, DLY_1U);
                           phase_in = PH_AK_REL;
                        end
                     end
                     PH_AK_REL: begin
                        scl_in = 1'b1; sda_in = 1'b1; en_in = 1'b0;
                        delay_in = calc_delay(unit_ticks, DLY_1U);
                        phase_in = PH_AK_HI;
                     end
                     PH_AK_HI: begin
                        wait_in  = 16'd0;
                        phase_in = PH_AK_POLL;
                     end
                     PH_RD_LO: begin
                        scl_in = 1'b1; sda_in = 1'b1; en_in = 1'b0;
                        shift_in = {shift_ff[6:0], q_item.sda_in};
                        bit_in   = bit_ff + 4'd1;
                        delay_in = calc_delay(unit_ticks, DLY_1U);
                        phase_in = PH_RD_HI;
                     end
                     PH_RD_HI: begin
                        if (bit_ff < 4'd8) begin
                           scl_in = 1'b0; sda_in = 1'b1; en_in = 1'b0;
                           delay_in = calc_delay(unit_ticks, DLY_2U);
                           phase_in = PH_RD_LO;
                        end else begin
                           rx_in  = shift_ff;
                           scl_in = 1'b0; sda_in = !ack_ff; en_in = 1'b1;
                           delay_in = calc_delay(unit_ticks, DLY_2U);
                           phase_in = PH_AC_LO;
                        end
                     end
                     PH_AC_LO: begin
                        scl_in = 1'b1; en_in = 1'b1;
                        delay_in = calc_delay(unit_ticks, DLY_2U);
                        phase_in = PH_AC_HI;
                     end
                     PH_AC_HI: begin
                        scl_in = 1'b0; en_in = 1'b1;
                        phase_in = PH_IDLE;
                        done     = 1'b1;
                     end
                     default: phase_in = PH_IDLE;
                  endcase
               end
            end
         endcase
      end

      rsp_in.scl_out      = scl_in;
      rsp_in.sda_out      = sda_in;
      rsp_in.sda_drive_en = en_in;
      rsp_in.busy_res     = (phase_in != PH_IDLE);
      rsp_in.done_res     = done;
      rsp_in.rx_byte      = rx_in;
      rsp_in.ack_failed   = fail_in;
      rsp_valid_in        = step || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bit_ff       <= 4'd0;
         shift_ff     <= 8'd0;
         delay_ff     <= 18'd0;
         wait_ff      <= 16'd0;
         ack_ff       <= 1'b0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         en_ff        <= 1'b1;
         fail_ff      <= 1'b0;
         rx_ff        <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         bit_ff       <= bit_in;
         shift_ff     <= shift_in;
         delay_ff     <= delay_in;
         wait_ff      <= wait_in;
         ack_ff       <= ack_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in;
         en_ff        <= en_in;
         fail_ff      <= fail_in;
         rx_ff        <= rx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ----- hdl/i2c_bit_level_master.sv -----
// Top level of the I2C bit-level master: register port, request queue, bit engine.
// An accepted request waits in the queue until the engine steps on it; the engine then
// holds its result in the result register until taken. Throughput: one request per cycle
// unless results stall; the engine advances the bus sequencer one tick per request, and a
// two-entry queue plus a result register decouple both streams.
// Reset (synchronous, active high): engine idle, SCL and SDA high and driven,
// flags and received byte zero, unit_ticks 100, ack_timeout_ticks 250.
module i2c_bit_level_master
   import i2cbm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // func[2:0], tx_byte[10:3], send_ack[11], sda_in[12]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // scl_out[0], sda_out[1], sda_drive_en[2], busy_res[3],
                                    // done_res[4], rx_byte[12:5], ack_failed[13]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [15:0] unit_ticks_ff, unit_ticks_in;
   logic [15:0] timeout_ff, timeout_in;
   logic        csr_wr;
   logic        q_valid;
   item_type    q_item;
   logic        q_pop;
   result_type  rsp_result;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unit_ticks_in = unit_ticks_ff;
      timeout_in    = timeout_ff;
      if (csr_wr && csr_paddr == CSR_ADDR_UNIT) begin
         unit_ticks_in = csr_pwdata[15:0];
      end
      if (csr_wr && csr_paddr == CSR_ADDR_TIMEOUT) begin
         timeout_in = csr_pwdata[15:0];
      end
      unique case (csr_paddr)
         CSR_ADDR_UNIT:    csr_prdata = {16'd0, unit_ticks_ff};
         CSR_ADDR_TIMEOUT: csr_prdata = {16'd0, timeout_ff};
         default:          csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ticks_ff <= UNIT_TICKS_RESET;
         timeout_ff    <= ACK_TIMEOUT_RESET;
      end else begin
         unit_ticks_ff <= unit_ticks_in;
         timeout_ff    <= timeout_in;
      end
   end

   i2cbm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   i2cbm_engine u_engine (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop),
      .unit_ticks        (unit_ticks_ff),
      .ack_timeout_ticks (timeout_ff),
      .rsp_valid         (rsp_tvalid),
      .rsp_ready         (rsp_tready),
      .rsp_result        (rsp_result)
   );

   assign rsp_tdata = {2'b00, rsp_result};

endmodule
